// ----- sv/wpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Function codes and special pattern bytes shared by the matcher modules.
// ----------------------------------------------------------------------------
package wpm_pkg;

	typedef logic [1:0] func_t;
	typedef logic [7:0] char_t;

	// Function codes carried on the input channel.
	localparam func_t FUNC_LOAD  = 2'd0;
	localparam func_t FUNC_BEGIN = 2'd1;
	localparam func_t FUNC_TEXT  = 2'd2;

	// Pattern bytes with wildcard meaning.
	localparam char_t STAR_CHAR  = 8'h2A;
	localparam char_t QMARK_CHAR = 8'h3F;

	// Width of the pattern length register.
	localparam int LEN_REG_W = 5;

endpackage

// ----- sv/wildcard_pattern_matcher_top.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Streams text bytes against a stored pattern with '*' and '?' wildcards.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries func, position and
// char_value. A load transfer writes one pattern byte, a begin transfer
// starts a new text and a text transfer feeds one text byte. Begin and text
// transfers each produce one result transfer on the output channel
// (out_valid/out_ready) with matched and no_match_possible; loads and the
// unused function code produce none. The pattern length is written through
// the configuration channel (cfg_valid/cfg_ready/cfg_data), which is always
// ready and should only be used while the block is idle.
// A result passes through the queue and the result register after its input
// transfer; the block sustains one item per cycle while out_ready stays high,
// with the row update a chain of AND and OR terms across all pattern positions.
// Reset clears the match row, the length and all handshake state; the
// pattern store holds no value until loaded. When the receiver stalls, the
// result register holds, the two-entry queue fills, and in_ready then drops.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher_top import wpm_pkg::*; #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  func_t                func,
	input  logic [3:0]           position,
	input  char_t                char_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 matched,
	output logic                 no_match_possible,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LEN_REG_W-1:0] cfg_data
);

	localparam int EW = 2 * MAX_PATTERN + 1;

	logic [LEN_REG_W-1:0] pattern_length_q;
	logic                 push;
	logic [EW-1:0]        push_entry;
	logic                 pop;
	logic [EW-1:0]        pop_entry;
	logic                 q_full;
	logic                 q_empty;

	// The length register takes every configuration transfer.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			pattern_length_q <= cfg_data;
		end
	end

	// Front end: accepts items, keeps the pattern and classifies each byte.
	wpm_front #(
		.MaxPattern (MAX_PATTERN)
	) u_front (
		.clk        (clk),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.position   (position),
		.char_value (char_value),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Queue between the two halves so each can stall on its own.
	wpm_queue #(
		.Width (EW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.full       (q_full),
		.empty      (q_empty)
	);

	// Back end: advances the match row and drives the result register.
	wpm_back #(
		.MaxPattern (MAX_PATTERN)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pattern_length    (pattern_length_q),
		.q_empty           (q_empty),
		.q_entry           (pop_entry),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.matched           (matched),
		.no_match_possible (no_match_possible)
	);

endmodule

// ----- sv/wpm_front.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher front end
// Takes input transfers, keeps the pattern store and turns each begin or
// text item into per-position star and hit masks for the back end.
// ----------------------------------------------------------------------------
module wpm_front import wpm_pkg::*; #(
	parameter int MaxPattern = 16
) (
	input  logic                    clk,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  func_t                   func,
	input  logic [3:0]              position,
	input  char_t                   char_value,
	input  logic                    q_full,
	output logic                    push,
	output logic [2*MaxPattern:0]   push_entry
);

	localparam int PW = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;

	char_t                   pattern_q [MaxPattern];
	logic                    accept;
	logic                    load_en;
	logic [PW-1:0]           load_idx;
	logic [MaxPattern-1:0]   star;
	logic [MaxPattern-1:0]   hit;

	assign in_ready = ~q_full;
	assign accept   = in_valid & in_ready;

	// A load beyond the store depth is dropped.
	assign load_en  = accept && (func == FUNC_LOAD) && (int'(position) < MaxPattern);
	assign load_idx = PW'(position);

	always_ff @(posedge clk) begin
		if (load_en) begin
			pattern_q[load_idx] <= char_value;
		end
	end

	// Classify each pattern position against the incoming text byte.
	always_comb begin
		for (int j = 0; j < MaxPattern; j++) begin
			star[j] = (pattern_q[j] == STAR_CHAR);
			hit[j]  = (pattern_q[j] == QMARK_CHAR) || (pattern_q[j] == char_value);
		end
	end

	assign push       = accept && ((func == FUNC_BEGIN) || (func == FUNC_TEXT));
	assign push_entry = {(func == FUNC_BEGIN), star, hit};

endmodule

// ----- sv/wpm_queue.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher queue
// Two-entry FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module wpm_queue #(
	parameter int Width = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_entry,
	input  logic             pop,
	output logic [Width-1:0] pop_entry,
	output logic             full,
	output logic             empty
);

	logic [Width-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign empty     = (count_q == 2'd0);
	assign pop_entry = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/wpm_back.sv -----
// ----------------------------------------------------------------------------
// Wildcard pattern matcher back end
// Advances the prefix-match row by one item and holds the result register.
// ----------------------------------------------------------------------------
module wpm_back import wpm_pkg::*; #(
	parameter int MaxPattern = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [LEN_REG_W-1:0]    pattern_length,
	input  logic                    q_empty,
	input  logic [2*MaxPattern:0]   q_entry,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    matched,
	output logic                    no_match_possible
);

	localparam int LW = $clog2(MaxPattern + 1);
	localparam int CW = (LW > LEN_REG_W) ? LW : LEN_REG_W;

	logic [MaxPattern:0]     row_q;
	logic [MaxPattern:0]     nxt;
	logic                    is_begin;
	logic [MaxPattern-1:0]   star;
	logic [MaxPattern-1:0]   hit;
	logic [CW-1:0]           len_wide;
	logic [LW-1:0]           eff_len;
	logic                    out_valid_q;
	logic                    matched_q;
	logic                    nmp_q;

	assign {is_begin, star, hit} = q_entry;

	// A length above the store depth is used as the store depth.
	assign len_wide = CW'(pattern_length);
	assign eff_len  = (len_wide > CW'(MaxPattern)) ? LW'(MaxPattern) : LW'(len_wide);

	// Row update: on begin only leading stars extend; on text a star extends its left
	// neighbor or keeps its own bit, any other position takes the previous bit when the byte fits.
	always_comb begin
		nxt    = '0;
		nxt[0] = is_begin;
		for (int j = 1; j <= MaxPattern; j++) begin
			if (is_begin) begin
				nxt[j] = nxt[j-1] & star[j-1];
			end else if (star[j-1]) begin
				nxt[j] = nxt[j-1] | row_q[j];
			end else begin
				nxt[j] = hit[j-1] & row_q[j-1];
			end
			nxt[j] = nxt[j] & (j <= int'(eff_len));
		end
	end

	assign pop = ~q_empty & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				row_q <= nxt;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			matched_q <= nxt[eff_len];
			nmp_q     <= ~|nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign matched           = matched_q;
	assign no_match_possible = nmp_q;

endmodule
